[design/arith_encode_step_defines.svh]
// assertion macros shared by the arithmetic encoder rtl
// depends on nothing; included by modules that carry assertions
`ifndef ARITH_ENCODE_STEP_DEFINES_SVH
`define ARITH_ENCODE_STEP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arith encoder check failed");

// next-cycle implication, checked out of reset
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arith encoder check failed");

`endif

[design/aes_pkg.sv]
// shared constants, controller/datapath command and status types, helpers
// depends on nothing
package aes_pkg;

    localparam int CODE_BITS_DEF      = 16;
    localparam int UNDERFLOW_BITS_DEF = 16;
    localparam int MAX_RESULTS        = 17;
    localparam int COUNT_W            = 14;
    localparam int FOLLOW_W           = 17;
    localparam logic [FOLLOW_W-1:0] FOLLOW_MAX = '1;

    typedef struct packed {
        logic capture;
        logic mul_load;
        logic sel_lo;
        logic div_step;
        logic store_qh;
        logic bound_update;
        logic renorm_step;
        logic push_flush;
        logic push_empty;
        logic push_final;
    } t_dp_cmd;

    typedef struct packed {
        logic is_flush;
        logic zero_scale;
        logic div_last;
        logic renorm_stop;
        logic iter_last;
        logic out_free;
    } t_dp_status;

    // clamp a run length to the width of the follow field
    function automatic logic [FOLLOW_W-1:0] sat_follow(input logic [32:0] v);
        logic [FOLLOW_W-1:0] r;
        if (v > 33'(FOLLOW_MAX)) begin
            r = FOLLOW_MAX;
        end else begin
            r = v[FOLLOW_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/aes_ctrl.sv]
// sequencing state machine of the arithmetic encoder
// depends on aes_pkg; drives the datapath through t_dp_cmd
module aes_ctrl
    import aes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_FLUSH  = 11'b00000000100,
        S_EMPTY  = 11'b00000001000,
        S_MUL_HI = 11'b00000010000,
        S_DIV_HI = 11'b00000100000,
        S_MUL_LO = 11'b00001000000,
        S_DIV_LO = 11'b00010000000,
        S_UPDATE = 11'b00100000000,
        S_RENORM = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_flush) begin
                    n_state = S_FLUSH;
                end else if (i_status.zero_scale) begin
                    n_state = S_EMPTY;
                end else begin
                    n_state = S_MUL_HI;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push_flush = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.push_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_DIV_HI;
            end
            S_DIV_HI: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.store_qh = 1'b1;
                    n_state        = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.sel_lo   = 1'b1;
                n_state        = S_DIV_LO;
            end
            S_DIV_LO: begin
                o_cmd.div_step = 1'b1;
                o_cmd.sel_lo   = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.bound_update = 1'b1;
                n_state            = S_RENORM;
            end
            S_RENORM: begin
                // one shift per cycle, paced by the output register
                if (i_status.out_free) begin
                    if (i_status.renorm_stop) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.renorm_step = 1'b1;
                        if (i_status.iter_last) begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.push_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/aes_dp.sv]
// datapath: bounds, multiplier, serial divider, renormalizer, result register
// depends on aes_pkg and arith_encode_step_defines.svh; commanded by aes_ctrl
`include "arith_encode_step_defines.svh"

module aes_dp
    import aes_pkg::*;
#(
    parameter int CODE_BITS      = CODE_BITS_DEF,
    parameter int UNDERFLOW_BITS = UNDERFLOW_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic                i_req,
    input  logic [COUNT_W-1:0]  i_low_count,
    input  logic [COUNT_W-1:0]  i_high_count,
    input  logic [COUNT_W-1:0]  i_total_scale,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_has_bits,
    output logic                o_lead_bit,
    output logic [FOLLOW_W-1:0] o_follow_count,
    output logic                o_last
);

    localparam int CB  = CODE_BITS;
    localparam int UB  = UNDERFLOW_BITS;
    localparam int PW  = CB + 1 + COUNT_W;      // product and dividend width
    localparam int DCW = $clog2(PW);
    localparam int ITW = $clog2(CB);
    localparam int EW  = $clog2(MAX_RESULTS + 1);

    // coder state
    logic [CB-1:0] r_low, n_low, r_high, n_high;
    logic [UB-1:0] r_pend, n_pend;
    // captured item
    logic               r_req;
    logic [COUNT_W-1:0] r_lc, r_hc, r_scale;
    // divider
    logic [PW-1:0]      r_dvd, n_dvd;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [DCW-1:0]     r_div_cnt, n_div_cnt;
    logic [CB-1:0]      r_qh;
    // renormalizer
    logic [ITW-1:0]      r_iter, n_iter;
    logic [EW-1:0]       r_emit_cnt, n_emit_cnt;
    logic                r_hold_valid, n_hold_valid;
    logic                r_hold_lead, n_hold_lead;
    logic [FOLLOW_W-1:0] r_hold_follow, n_hold_follow;
    // result register
    logic                r_out_valid, n_out_valid;
    logic                r_out_has, n_out_has;
    logic                r_out_lead, n_out_lead;
    logic [FOLLOW_W-1:0] r_out_follow, n_out_follow;
    logic                r_out_last, n_out_last;

    logic [CB:0]        rng;
    logic [PW-1:0]      product;
    logic [COUNT_W:0]   rem_sh;
    logic               q_bit;
    logic               top_eq, uf_case, emit, out_free;
    logic [CB-1:0]      low_m, high_m;

    assign out_free = !r_out_valid || i_out_ready;
    assign rng      = {1'b0, r_high - r_low} + (CB+1)'(1);
    assign product  = PW'(rng) * PW'(i_cmd.sel_lo ? r_lc : r_hc);

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[PW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_scale});

    assign top_eq  = (r_high[CB-1] == r_low[CB-1]);
    assign uf_case = !top_eq && r_low[CB-2] && !r_high[CB-2];
    assign emit    = top_eq && (r_emit_cnt < EW'(MAX_RESULTS));

    always_comb begin
        low_m  = r_low;
        high_m = r_high;
        if (uf_case) begin
            low_m[CB-2]  = 1'b0;
            high_m[CB-2] = 1'b1;
        end
    end

    always_comb begin
        o_status.is_flush    = r_req;
        o_status.zero_scale  = (r_scale == '0);
        o_status.div_last    = (r_div_cnt == DCW'(PW - 1));
        o_status.renorm_stop = !top_eq && !uf_case;
        o_status.iter_last   = (r_iter == ITW'(CB - 1));
        o_status.out_free    = out_free;
    end

    always_comb begin
        n_low         = r_low;
        n_high        = r_high;
        n_pend        = r_pend;
        n_dvd         = r_dvd;
        n_rem         = r_rem;
        n_div_cnt     = r_div_cnt;
        n_iter        = r_iter;
        n_emit_cnt    = r_emit_cnt;
        n_hold_valid  = r_hold_valid;
        n_hold_lead   = r_hold_lead;
        n_hold_follow = r_hold_follow;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_has     = r_out_has;
        n_out_lead    = r_out_lead;
        n_out_follow  = r_out_follow;
        n_out_last    = r_out_last;

        if (i_cmd.capture) begin
            n_iter       = '0;
            n_emit_cnt   = '0;
            n_hold_valid = 1'b0;
        end

        if (i_cmd.mul_load) begin
            n_dvd     = product;
            n_rem     = '0;
            n_div_cnt = '0;
        end

        if (i_cmd.div_step) begin
            n_rem     = q_bit ? COUNT_W'(rem_sh - {1'b0, r_scale}) : COUNT_W'(rem_sh);
            n_dvd     = {r_dvd[PW-2:0], q_bit};
            n_div_cnt = r_div_cnt + DCW'(1);
        end

        if (i_cmd.bound_update) begin
            // low quotient is left in the dividend register
            n_high = r_low + r_qh - CB'(1);
            n_low  = r_low + r_dvd[CB-1:0];
        end

        if (i_cmd.renorm_step) begin
            n_iter = r_iter + ITW'(1);
            n_low  = {low_m[CB-2:0], 1'b0};
            n_high = {high_m[CB-2:0], 1'b1};
            if (top_eq) begin
                n_pend = '0;
                if (emit) begin
                    // previous emission is now known not to be the last one
                    if (r_hold_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_has    = 1'b1;
                        n_out_lead   = r_hold_lead;
                        n_out_follow = r_hold_follow;
                        n_out_last   = 1'b0;
                    end
                    n_hold_valid  = 1'b1;
                    n_hold_lead   = r_high[CB-1];
                    n_hold_follow = sat_follow(33'(r_pend));
                    n_emit_cnt    = r_emit_cnt + EW'(1);
                end
            end else if (uf_case && (r_pend != '1)) begin
                n_pend = r_pend + UB'(1);
            end
        end

        if (i_cmd.push_flush) begin
            n_out_valid  = 1'b1;
            n_out_has    = 1'b1;
            n_out_lead   = r_low[CB-2];
            n_out_follow = sat_follow(33'(r_pend) + 33'd1);
            n_out_last   = 1'b1;
            n_low        = '0;
            n_high       = '1;
            n_pend       = '0;
        end

        if (i_cmd.push_empty || i_cmd.push_final) begin
            n_out_valid  = 1'b1;
            n_out_last   = 1'b1;
            n_out_has    = 1'b0;
            n_out_lead   = 1'b0;
            n_out_follow = '0;
            if (i_cmd.push_final && r_hold_valid) begin
                n_out_has    = 1'b1;
                n_out_lead   = r_hold_lead;
                n_out_follow = r_hold_follow;
            end
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_high       <= '1;
            r_pend       <= '0;
            r_div_cnt    <= '0;
            r_iter       <= '0;
            r_emit_cnt   <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_low        <= n_low;
            r_high       <= n_high;
            r_pend       <= n_pend;
            r_div_cnt    <= n_div_cnt;
            r_iter       <= n_iter;
            r_emit_cnt   <= n_emit_cnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req;
            r_lc    <= i_low_count;
            r_hc    <= i_high_count;
            r_scale <= i_total_scale;
        end
        if (i_cmd.store_qh) begin
            r_qh <= n_dvd[CB-1:0];
        end
        r_dvd         <= n_dvd;
        r_rem         <= n_rem;
        r_hold_lead   <= n_hold_lead;
        r_hold_follow <= n_hold_follow;
        r_out_has     <= n_out_has;
        r_out_lead    <= n_out_lead;
        r_out_follow  <= n_out_follow;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_bits     = r_out_has;
    assign o_lead_bit     = r_out_lead;
    assign o_follow_count = r_out_follow;
    assign o_last         = r_out_last;

    `AES_ASSERT_NEXT(a_flush_resets, i_clk, i_rst_n, i_cmd.push_flush,
        (r_low == '0) && (r_high == '1) && (r_pend == '0))
    `AES_ASSERT_NEXT(a_rem_below_scale, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_scale)
    `AES_ASSERT_NOW(a_hold_counted, i_clk, i_rst_n, r_hold_valid, r_emit_cnt != '0)

endmodule

[design/arith_encode_step.sv]
// arithmetic encoder top: aes_ctrl sequencer and aes_dp datapath, constants from aes_pkg
// encode item: multiply and bit-serial divide for the high bound, then for the low bound,
// bounds update, up to CODE_BITS renormalization shifts and the final result push;
// flush and zero-scale items push their one result straight after decoding
// one item at a time, ready the cycle after its last result loads; full output stalls shifts
// synchronous active-low reset: low 0, high all ones, no pending underflow bits
module arith_encode_step
    import aes_pkg::*;
#(
    parameter int CODE_BITS      = CODE_BITS_DEF,
    parameter int UNDERFLOW_BITS = UNDERFLOW_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // low_count[13:0], high_count[13:0], total_scale[13:0]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // lead_bit, follow_count[16:0]
    output logic        m_axis_tuser,   // has_bits
    output logic        m_axis_tlast
);

    t_dp_cmd             cmd;
    t_dp_status          status;
    logic                lead_bit;
    logic [FOLLOW_W-1:0] follow_count;

    aes_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    aes_dp #(
        .CODE_BITS      (CODE_BITS),
        .UNDERFLOW_BITS (UNDERFLOW_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req          (s_axis_tuser),
        .i_low_count    (s_axis_tdata[13:0]),
        .i_high_count   (s_axis_tdata[27:14]),
        .i_total_scale  (s_axis_tdata[41:28]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_has_bits     (m_axis_tuser),
        .o_lead_bit     (lead_bit),
        .o_follow_count (follow_count),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, follow_count, lead_bit};

endmodule

[verif/tb_arith_encode_step.sv]
// self-checking testbench for arith_encode_step: drives encode and flush items over the
// input stream, predicts every bit run in a behavioral coder model and checks the output
// depends on aes_pkg and arith_encode_step from the design folder
module tb_arith_encode_step;
    import aes_pkg::*;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;
    localparam logic [15:0] PENDING_MAX = 16'hFFFF;
    localparam logic [15:0] QTR_MASK    = 16'h3FFF;
    localparam logic [15:0] QTR_SET     = 16'h4000;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 200;
    // symbol straddling one half; piles up underflow bits
    localparam int MID_LOW   = 8191;
    localparam int MID_HIGH  = 8192;
    localparam int MID_SCALE = 16383;
    localparam int RUN_ITEMS = 6;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] low_count;
        logic [COUNT_W-1:0] high_count;
        logic [COUNT_W-1:0] total_scale;
    } sym_req_t;

    typedef struct packed {
        logic                has_bits;
        logic                lead_bit;
        logic [FOLLOW_W-1:0] follow_count;
        logic                last;
    } bit_run_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sym_req_t cur_item = '0;
    logic     in_fire = 1'b0;
    sym_req_t pending_items[$];
    bit_run_t expected_runs[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    int n_items = 0;
    int n_flush = 0;
    int n_zero = 0;
    int n_runs = 0;
    int peak_pending = 0;

    // behavioral coder state
    logic [15:0] coder_low = 16'h0000;
    logic [15:0] coder_high = 16'hFFFF;
    logic [15:0] coder_pending = 16'h0000;

    assign s_tdata = {6'b0, cur_item.total_scale, cur_item.high_count, cur_item.low_count};
    assign s_tuser = cur_item.req_type;

    arith_encode_step u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser),
        .m_axis_tlast (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // narrow the bounds for one item and renormalize, queueing the bit runs it emits
    task automatic advance_coder(input sym_req_t r);
        bit_run_t    fresh[$];
        logic [16:0] span;
        logic [63:0] q_hi;
        logic [63:0] q_lo;
        logic [15:0] lo;
        logic [15:0] hi;
        bit          stop;
        if (r.req_type == REQ_FLUSH) begin
            fresh.push_back('{1'b1, coder_low[14], {1'b0, coder_pending} + 17'd1, 1'b1});
            coder_low = 16'h0000;
            coder_high = 16'hFFFF;
            coder_pending = 16'h0000;
        end else if (r.total_scale == 0) begin
            fresh.push_back('{1'b0, 1'b0, '0, 1'b1});
        end else begin
            span = {1'b0, coder_high - coder_low} + 17'd1;
            q_hi = 64'(span) * 64'(r.high_count) / 64'(r.total_scale);
            q_lo = 64'(span) * 64'(r.low_count) / 64'(r.total_scale);
            hi = 16'(64'(coder_low) + q_hi - 64'd1);
            lo = 16'(64'(coder_low) + q_lo);
            stop = 1'b0;
            for (int i = 0; i < 16 && !stop; i++) begin
                if (hi[15] == lo[15]) begin
                    fresh.push_back('{1'b1, hi[15], {1'b0, coder_pending}, 1'b0});
                    coder_pending = 16'h0000;
                end else if (lo[14] && !hi[14]) begin
                    if (coder_pending != PENDING_MAX) coder_pending++;
                    lo = lo & QTR_MASK;
                    hi = hi | QTR_SET;
                end else begin
                    stop = 1'b1;
                end
                if (!stop) begin
                    lo = {lo[14:0], 1'b0};
                    hi = {hi[14:0], 1'b1};
                end
            end
            coder_low = lo;
            coder_high = hi;
            if (int'(coder_pending) > peak_pending) peak_pending = coder_pending;
            if (fresh.size() == 0) begin
                fresh.push_back('{1'b0, 1'b0, '0, 1'b1});
            end else begin
                fresh[fresh.size()-1].last = 1'b1;
            end
        end
        foreach (fresh[k]) expected_runs.push_back(fresh[k]);
    endtask

    // input acceptance and output checking, both at the rising edge
    always @(posedge i_clk) begin
        bit_run_t want;
        bit_run_t seen;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                n_items++;
                if (cur_item.req_type == REQ_FLUSH) n_flush++;
                else if (cur_item.total_scale == 0) n_zero++;
                advance_coder(cur_item);
            end
            if (m_tvalid && m_tready) begin
                seen = '{m_tuser, m_tdata[0], m_tdata[17:1], m_tlast};
                n_runs++;
                if (expected_runs.size() == 0) begin
                    $error("unexpected result item: has_bits %0d lead_bit %0d follow_count %0d",
                           seen.has_bits, seen.lead_bit, seen.follow_count);
                    errors++;
                end else begin
                    want = expected_runs.pop_front();
                    if (seen.has_bits !== want.has_bits) begin
                        $error("has_bits: expected %0d, got %0d", want.has_bits, seen.has_bits);
                        errors++;
                    end
                    if (seen.lead_bit !== want.lead_bit) begin
                        $error("lead_bit: expected %0d, got %0d", want.lead_bit, seen.lead_bit);
                        errors++;
                    end
                    if (seen.follow_count !== want.follow_count) begin
                        $error("follow_count: expected %0d, got %0d",
                               want.follow_count, seen.follow_count);
                        errors++;
                    end
                    if (seen.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, seen.last);
                        errors++;
                    end
                end
            end
        end
    end

    // driver and receiver stalls, changing at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || in_fire) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_item <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_item(input logic req, input int lc, input int hc, input int sc);
        pending_items.push_back('{req, COUNT_W'(lc), COUNT_W'(hc), COUNT_W'(sc)});
    endtask

    // mostly well-formed symbols, with flushes, zero scales, middle symbols and raw noise
    task automatic queue_random(input int count);
        int pick;
        int sc;
        int lc;
        int hc;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_item(REQ_FLUSH, $urandom_range(16383), $urandom_range(1, 16383),
                           $urandom_range(16383));
            end else if (pick < 11) begin
                queue_item(REQ_ENCODE, $urandom_range(16383), $urandom_range(1, 16383), 0);
            end else if (pick < 21) begin
                queue_item(REQ_ENCODE, $urandom_range(16383), $urandom_range(1, 16383),
                           $urandom_range(1, 16383));
            end else if (pick < 30) begin
                sc = $urandom_range(2, 16383);
                lc = (sc - 1) / 2 - $urandom_range(1);
                queue_item(REQ_ENCODE, lc, lc + 1 + $urandom_range(1), sc);
            end else begin
                sc = ($urandom_range(9) < 6) ? $urandom_range(2, 64) : $urandom_range(2, 16383);
                lc = $urandom_range(sc - 1);
                hc = $urandom_range(sc, lc + 1);
                queue_item(REQ_ENCODE, lc, hc, sc);
            end
        end
    endtask

    // hold off until everything queued is accepted and every result has come back
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid) @(posedge i_clk);
        while (expected_runs.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 49;
        queue_item(REQ_FLUSH, 0, 1, 0);               // flush straight out of reset
        queue_item(REQ_ENCODE, 0, 16383, 16383);      // whole range, nothing to emit
        queue_item(REQ_ENCODE, 5, 9, 0);              // zero scale leaves the bounds alone
        queue_item(REQ_ENCODE, 0, 1, 16383);          // tiny slice, long run of emitted bits
        queue_item(REQ_ENCODE, 16383, 16383, 16383);  // empty slice at the top
        queue_item(REQ_ENCODE, 9000, 100, 10000);     // high count below low count
        queue_item(REQ_ENCODE, 16383, 16383, 1);      // counts far above the scale
        queue_item(REQ_FLUSH, 16383, 16383, 16383);
        queue_item(REQ_ENCODE, MID_LOW, MID_HIGH, MID_SCALE);
        queue_item(REQ_ENCODE, MID_LOW, MID_HIGH, MID_SCALE);
        queue_item(REQ_ENCODE, 1, 3, 4);
        queue_item(REQ_ENCODE, 0, 1, 16383);          // emits with pending bits
        queue_item(REQ_ENCODE, MID_LOW, MID_HIGH, MID_SCALE);
        queue_item(REQ_FLUSH, 0, 1, 1);               // flush carrying underflow bits
        queue_item(REQ_ENCODE, 5000, 16000, 16383);
        queue_item(REQ_FLUSH, 0, 1, 1);
        queue_item(REQ_ENCODE, 0, 16383, 1);          // high count above the scale
        queue_item(REQ_ENCODE, 8191, 16383, 16383);
        queue_item(REQ_ENCODE, 1, 2, 3);
        queue_item(REQ_FLUSH, 0, 1, 1);
        wait_drained();
        queue_random(40);
        wait_drained();

        tx_idle_pct = 49;
        rx_idle_pct = 20;
        queue_random(40);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(40);
        wait_drained();
        // build up a long underflow run, then flush it out
        queue_item(REQ_FLUSH, 0, 1, 1);
        for (int i = 0; i < RUN_ITEMS; i++) queue_item(REQ_ENCODE, MID_LOW, MID_HIGH, MID_SCALE);
        queue_item(REQ_FLUSH, 0, 1, 1);
        queue_item(REQ_ENCODE, 0, 1, 16383);
        queue_item(REQ_FLUSH, 0, 1, 1);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_runs.size() != 0) begin
            $error("%0d expected result items never arrived", expected_runs.size());
            errors++;
        end
        $display("covered %0d input items (%0d flushes, %0d zero-scale) and %0d result items",
                 n_items, n_flush, n_zero, n_runs);
        $display("deepest underflow run reached %0d, over %0d cycles", peak_pending, cycles);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
